FILE: rtl/rbp_pkg.sv
`default_nettype none

package rbp_pkg;

    // Opcodes of the routine program
    localparam logic [7:0] OP_GROUP = 8'hEE;
    localparam logic [7:0] OP_END   = 8'hFF;
    localparam logic [7:0] OP_POS   = 8'hAA;
    localparam logic [7:0] OP_SPD   = 8'hBB;
    localparam logic [7:0] OP_LOCK  = 8'hCC;
    localparam logic [7:0] OP_FUNC  = 8'hDD;

    // Number of selectable callbacks and of addressable actuators
    localparam logic [7:0] FUNC_COUNT    = 8'd3;
    localparam logic [3:0] MAX_ACTUATORS = 4'd8;
    localparam logic [3:0] LIMIT_RESET   = 4'd8;

    // Record kinds
    localparam logic [2:0] K_GROUP = 3'd0;
    localparam logic [2:0] K_POS   = 3'd1;
    localparam logic [2:0] K_SPD   = 3'd2;
    localparam logic [2:0] K_LOCK  = 3'd3;
    localparam logic [2:0] K_FUNC  = 3'd4;
    localparam logic [2:0] K_END   = 3'd5;
    localparam logic [2:0] K_ERR   = 3'd6;

    // Error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_OPCODE   = 3'd1;
    localparam logic [2:0] E_ACTUATOR = 3'd2;
    localparam logic [2:0] E_FUNCTION = 3'd3;
    localparam logic [2:0] E_NO_GROUP = 3'd4;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE        = 8'b0000_0001,
        PH_OPCODE      = 8'b0000_0010,
        PH_POS_INDEX   = 8'b0000_0100,
        PH_POS_VALUE   = 8'b0000_1000,
        PH_SPD_INDEX   = 8'b0001_0000,
        PH_SPD_CONTROL = 8'b0010_0000,
        PH_SPD_TIMEOUT = 8'b0100_0000,
        PH_FUNC_INDEX  = 8'b1000_0000
    } phase_t;

    // Input word
    typedef struct packed {
        logic [7:0] program_byte;
        logic       routine_start;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [2:0]  actuator_number;
        logic [7:0]  position_code;
        logic [7:0]  speed_control;
        logic [31:0] timeout_value;
        logic [1:0]  function_number;
        logic [7:0]  group_number;
        logic [2:0]  fault_code;
    } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/rbp_in_stage.sv
`default_nettype none

module rbp_in_stage
    import rbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_word,
    input  wire logic     advance,
    output logic          held_valid,
    output in_word_t      held_word
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_word_t in_word_reg;

    // The register takes a new word when empty or when its word moves on.
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    assign held_valid = in_valid_reg;
    assign held_word  = in_word_reg;

endmodule

`default_nettype wire

FILE: rtl/rbp_decode.sv
`default_nettype none

module rbp_decode
    import rbp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    input  wire logic [3:0] cfg_data,
    input  wire in_word_t  item,
    input  wire logic      step,
    output logic           res_valid,
    output out_word_t      res_word
);

    logic [3:0]  limit_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  act_reg, act_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic [23:0] tsh_reg, tsh_next;
    logic [1:0]  tcnt_reg, tcnt_next;
    logic        gop_reg, gop_next;
    logic [7:0]  gtot_reg, gtot_next;

    phase_t      ph;
    logic [2:0]  act;
    logic [7:0]  ctl;
    logic [23:0] tsh;
    logic [1:0]  tcnt;
    logic        gop;
    logic [7:0]  gtot;
    logic [7:0]  b;
    logic [3:0]  lim;
    logic        index_ok;

    // Limits above eight act as eight.
    assign b        = item.program_byte;
    assign lim      = (limit_reg > MAX_ACTUATORS) ? MAX_ACTUATORS : limit_reg;
    assign index_ok = b < {4'd0, lim};

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // One parser step per byte; a start flag clears the state first.
    always_comb begin
        ph   = item.routine_start ? PH_OPCODE : phase_reg;
        act  = item.routine_start ? 3'd0  : act_reg;
        ctl  = item.routine_start ? 8'd0  : ctl_reg;
        tsh  = item.routine_start ? 24'd0 : tsh_reg;
        tcnt = item.routine_start ? 2'd0  : tcnt_reg;
        gop  = item.routine_start ? 1'b0  : gop_reg;
        gtot = item.routine_start ? 8'd0  : gtot_reg;

        phase_next = ph;
        act_next   = act;
        ctl_next   = ctl;
        tsh_next   = tsh;
        tcnt_next  = tcnt;
        gop_next   = gop;
        gtot_next  = gtot;
        res_valid  = 1'b0;
        res_word   = '0;

        case (ph)
            PH_OPCODE: begin
                res_valid = 1'b1;
                if (b == OP_END) begin
                    phase_next           = PH_IDLE;
                    res_word.record_kind = K_END;
                end else if (b == OP_GROUP) begin
                    gop_next             = 1'b1;
                    gtot_next            = (gtot == 8'hFF) ? gtot : gtot + 8'd1;
                    res_word.record_kind = K_GROUP;
                end else if (b == OP_LOCK) begin
                    res_word.record_kind = K_LOCK;
                end else if (b == OP_POS || b == OP_SPD || b == OP_FUNC) begin
                    if (!gop) begin
                        phase_next           = PH_IDLE;
                        res_word.record_kind = K_ERR;
                        res_word.fault_code  = E_NO_GROUP;
                    end else begin
                        res_valid  = 1'b0;
                        phase_next = (b == OP_POS) ? PH_POS_INDEX :
                                     (b == OP_SPD) ? PH_SPD_INDEX : PH_FUNC_INDEX;
                    end
                end else begin
                    phase_next           = PH_IDLE;
                    res_word.record_kind = K_ERR;
                    res_word.fault_code  = E_OPCODE;
                end
            end
            PH_POS_INDEX, PH_SPD_INDEX: begin
                if (!index_ok) begin
                    res_valid            = 1'b1;
                    phase_next           = PH_IDLE;
                    res_word.record_kind = K_ERR;
                    res_word.fault_code  = E_ACTUATOR;
                end else begin
                    act_next   = b[2:0];
                    phase_next = (ph == PH_POS_INDEX) ? PH_POS_VALUE : PH_SPD_CONTROL;
                end
            end
            PH_POS_VALUE: begin
                res_valid                = 1'b1;
                phase_next               = PH_OPCODE;
                res_word.record_kind     = K_POS;
                res_word.actuator_number = act;
                res_word.position_code   = b;
            end
            PH_SPD_CONTROL: begin
                ctl_next   = b;
                tsh_next   = 24'd0;
                tcnt_next  = 2'd0;
                phase_next = PH_SPD_TIMEOUT;
            end
            PH_SPD_TIMEOUT: begin
                // Timeout bytes arrive least significant first.
                case (tcnt)
                    2'd0: begin
                        tsh_next  = tsh | {16'd0, b};
                        tcnt_next = 2'd1;
                    end
                    2'd1: begin
                        tsh_next  = tsh | {8'd0, b, 8'd0};
                        tcnt_next = 2'd2;
                    end
                    2'd2: begin
                        tsh_next  = tsh | {b, 16'd0};
                        tcnt_next = 2'd3;
                    end
                    default: begin
                        res_valid                = 1'b1;
                        tsh_next                 = 24'd0;
                        tcnt_next                = 2'd0;
                        phase_next               = PH_OPCODE;
                        res_word.record_kind     = K_SPD;
                        res_word.actuator_number = act;
                        res_word.speed_control   = ctl;
                        res_word.timeout_value   = {b, tsh};
                    end
                endcase
            end
            PH_FUNC_INDEX: begin
                res_valid = 1'b1;
                if (b >= FUNC_COUNT) begin
                    phase_next           = PH_IDLE;
                    res_word.record_kind = K_ERR;
                    res_word.fault_code  = E_FUNCTION;
                end else begin
                    phase_next               = PH_OPCODE;
                    res_word.record_kind     = K_FUNC;
                    res_word.function_number = b[1:0];
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // Every record carries the group count after this byte.
        res_word.group_number = gtot_next;
    end

    // Parser state advances only when the held word is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            act_reg   <= 3'd0;
            ctl_reg   <= 8'd0;
            tsh_reg   <= 24'd0;
            tcnt_reg  <= 2'd0;
            gop_reg   <= 1'b0;
            gtot_reg  <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            ctl_reg   <= ctl_next;
            tsh_reg   <= tsh_next;
            tcnt_reg  <= tcnt_next;
            gop_reg   <= gop_next;
            gtot_reg  <= gtot_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rbp_out_stage.sv
`default_nettype none

module rbp_out_stage
    import rbp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire out_word_t load_word,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_word
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;

    // A new record replaces the one being taken; otherwise the register drains.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_word_reg <= load_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/routine_bytecode_parser_top.sv
// Channel   Direction  Handshake            Word
// s_        in         s_valid / s_ready    in_word_t (program byte, start flag)
// m_        out        m_valid / m_ready    out_word_t (decoded record)
// cfg_      in         cfg_valid / cfg_ready  4-bit actuator limit
//
// One program byte is taken every cycle unless a blocked result register holds it back;
// a record is presented once its last byte has sat in the input register and the record
// has then been loaded into the result register.
// Reset is synchronous and active low: the limit returns to eight and the parser
// drops bytes until one carries the start flag.
// A stalled result register holds back only bytes that produce a record; s_ready
// follows m_ready combinationally. Configuration writes are taken in any cycle.
`default_nettype none

module routine_bytecode_parser_top
    import rbp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_word,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_word,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);

    logic      held_valid;
    in_word_t  held_word;
    logic      res_valid;
    out_word_t res_word;
    logic      advance;

    assign cfg_ready = 1'b1;

    // The held byte moves on unless it makes a record and the result register is blocked.
    assign advance = held_valid && (!res_valid || !m_valid || m_ready);

    rbp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    rbp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .item      (held_word),
        .step      (advance),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    rbp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_word (res_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

`default_nettype wire

FILE: tb/rbp_record_checker.sv
`timescale 1ns / 100ps

// Watches the program, record and configuration channels of the parser, works
// out the record that each accepted program word gives and compares it with the
// records that leave the block, oldest first.
module rbp_record_checker
    import rbp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_word_t    s_word,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_word_t   m_word,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [3:0]  cfg_data,
    output int unsigned      mismatch_count,
    output int unsigned      expected_left
);

    // Own copy of the parser state and of the actuator limit.
    logic [3:0]  actuator_limit;
    phase_t      parse_phase;
    logic [2:0]  held_actuator;
    logic [7:0]  held_control;
    logic [23:0] timeout_shift;
    logic [1:0]  timeout_count;
    logic        group_opened;
    logic [7:0]  group_total;

    out_word_t   awaited_records[$];
    out_word_t   next_record;
    out_word_t   oldest_record;
    bit          makes_record;

    // Decodes one program word and gives the record that it completes, if any.
    task decode_byte(input in_word_t w, output bit makes, output out_word_t rec);
        logic [7:0] b;
        logic [3:0] usable;
        logic [2:0] err;
        b = w.program_byte;
        usable = (actuator_limit > MAX_ACTUATORS) ? MAX_ACTUATORS : actuator_limit;
        err = E_NONE;
        makes = 1'b0;
        rec = '0;
        if (w.routine_start) begin
            parse_phase = PH_OPCODE;
            held_actuator = '0;
            held_control = '0;
            timeout_shift = '0;
            timeout_count = '0;
            group_opened = 1'b0;
            group_total = '0;
        end
        case (parse_phase)
            PH_OPCODE: begin
                if (b == OP_END) begin
                    parse_phase = PH_IDLE;
                    makes = 1'b1;
                    rec.record_kind = K_END;
                end else if (b == OP_GROUP) begin
                    group_opened = 1'b1;
                    if (group_total != 8'd255)
                        group_total++;
                    makes = 1'b1;
                    rec.record_kind = K_GROUP;
                end else if (b == OP_LOCK) begin
                    makes = 1'b1;
                    rec.record_kind = K_LOCK;
                end else if (b == OP_POS || b == OP_SPD || b == OP_FUNC) begin
                    // Actions and function selects need an open group.
                    if (!group_opened)
                        err = E_NO_GROUP;
                    else if (b == OP_POS)
                        parse_phase = PH_POS_INDEX;
                    else if (b == OP_SPD)
                        parse_phase = PH_SPD_INDEX;
                    else
                        parse_phase = PH_FUNC_INDEX;
                end else begin
                    err = E_OPCODE;
                end
            end
            PH_POS_INDEX, PH_SPD_INDEX: begin
                if (b >= {4'd0, usable}) begin
                    err = E_ACTUATOR;
                end else begin
                    held_actuator = b[2:0];
                    if (parse_phase == PH_POS_INDEX)
                        parse_phase = PH_POS_VALUE;
                    else
                        parse_phase = PH_SPD_CONTROL;
                end
            end
            PH_POS_VALUE: begin
                parse_phase = PH_OPCODE;
                makes = 1'b1;
                rec.record_kind = K_POS;
                rec.actuator_number = held_actuator;
                rec.position_code = b;
            end
            PH_SPD_CONTROL: begin
                held_control = b;
                timeout_shift = '0;
                timeout_count = '0;
                parse_phase = PH_SPD_TIMEOUT;
            end
            PH_SPD_TIMEOUT: begin
                // Timeout bytes arrive least significant first.
                if (timeout_count != 2'd3) begin
                    timeout_shift |= 24'(b) << (8 * timeout_count);
                    timeout_count++;
                end else begin
                    makes = 1'b1;
                    rec.record_kind = K_SPD;
                    rec.actuator_number = held_actuator;
                    rec.speed_control = held_control;
                    rec.timeout_value = {b, timeout_shift};
                    timeout_shift = '0;
                    timeout_count = '0;
                    parse_phase = PH_OPCODE;
                end
            end
            PH_FUNC_INDEX: begin
                if (b >= FUNC_COUNT) begin
                    err = E_FUNCTION;
                end else begin
                    parse_phase = PH_OPCODE;
                    makes = 1'b1;
                    rec.record_kind = K_FUNC;
                    rec.function_number = b[1:0];
                end
            end
            default: parse_phase = PH_IDLE;
        endcase
        // Any error closes the routine until the next start.
        if (err != E_NONE) begin
            parse_phase = PH_IDLE;
            makes = 1'b1;
            rec = '0;
            rec.record_kind = K_ERR;
            rec.fault_code = err;
        end
        rec.group_number = group_total;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on every accepted program word, then compare every accepted record.
    always @(posedge aclk) begin
        if (!aresetn) begin
            actuator_limit = LIMIT_RESET;
            parse_phase = PH_IDLE;
            held_actuator = '0;
            held_control = '0;
            timeout_shift = '0;
            timeout_count = '0;
            group_opened = 1'b0;
            group_total = '0;
            awaited_records.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_word, makes_record, next_record);
                if (makes_record)
                    awaited_records.push_back(next_record);
            end
            if (m_valid && m_ready) begin
                if (awaited_records.size() == 0) begin
                    $error("record word with none awaited: kind %0d, fault %0d",
                           m_word.record_kind, m_word.fault_code);
                    mismatch_count++;
                end else begin
                    oldest_record = awaited_records.pop_front();
                    check_field("record_kind", oldest_record.record_kind,
                                m_word.record_kind);
                    check_field("actuator_number", oldest_record.actuator_number,
                                m_word.actuator_number);
                    check_field("position_code", oldest_record.position_code,
                                m_word.position_code);
                    check_field("speed_control", oldest_record.speed_control,
                                m_word.speed_control);
                    check_field("timeout_value", oldest_record.timeout_value,
                                m_word.timeout_value);
                    check_field("function_number", oldest_record.function_number,
                                m_word.function_number);
                    check_field("group_number", oldest_record.group_number,
                                m_word.group_number);
                    check_field("fault_code", oldest_record.fault_code,
                                m_word.fault_code);
                end
            end
            // The limit is to change only while the parser is idle; the block does not enforce it.
            if (cfg_valid && cfg_ready)
                actuator_limit = cfg_data;
        end
        expected_left = awaited_records.size();
    end

endmodule

FILE: tb/tb_routine_bytecode_parser_top.sv
`timescale 1ns / 100ps

module tb_routine_bytecode_parser_top;
    import rbp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    int unsigned mismatch_count;
    int unsigned expected_left;

    int          sender_idle_pct = 14;
    int          receiver_idle_pct = 76;
    logic [3:0]  limit_setting = LIMIT_RESET;
    int          counted_bytes = 0;

    routine_bytecode_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rbp_record_checker record_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word         (m_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The record side stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Safety net against a hung handshake or a record that never comes.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one program word after a random gap and returns at its acceptance.
    task automatic send_word(input logic [7:0] b, input logic st);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= '{program_byte: b, routine_start: st};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lowers valid and waits until every record has left and the pipe is empty.
    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] good_index(input logic [3:0] usable);
        if (usable == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(usable - 1));
    endfunction

    // One routine: mostly well formed, now and then broken by a bad opcode, a
    // bad index, a bad function or a restart in the middle of an item.
    task automatic play_routine();
        logic [7:0] prog[$];
        logic [3:0] usable;
        logic [7:0] b;
        int         items;
        int         pick;
        bit         broken;
        usable = (limit_setting > MAX_ACTUATORS) ? MAX_ACTUATORS : limit_setting;
        broken = 1'b0;
        pick = $urandom_range(99);
        if (pick < 85)
            prog.push_back(OP_GROUP);
        else if (pick < 92)
            prog.push_back(OP_LOCK);
        else
            prog.push_back(8'($urandom_range(255)));
        items = $urandom_range(1, 12);
        for (int i = 0; i < items && !broken; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                prog.push_back(OP_GROUP);
            end else if (pick < 40) begin
                prog.push_back(OP_POS);
                prog.push_back(good_index(usable));
                prog.push_back(8'($urandom_range(255)));
                broken = (usable == 0);
            end else if (pick < 65) begin
                prog.push_back(OP_SPD);
                prog.push_back(good_index(usable));
                repeat (5) prog.push_back(8'($urandom_range(255)));
                broken = (usable == 0);
            end else if (pick < 75) begin
                prog.push_back(OP_LOCK);
            end else if (pick < 88) begin
                prog.push_back(OP_FUNC);
                prog.push_back(8'($urandom_range(2)));
            end else if (pick < 91) begin
                do b = 8'($urandom_range(255));
                while (b == OP_GROUP || b == OP_END || b == OP_POS || b == OP_SPD ||
                       b == OP_LOCK || b == OP_FUNC);
                prog.push_back(b);
                broken = 1'b1;
            end else if (pick < 93) begin
                prog.push_back($urandom_range(1) ? OP_POS : OP_SPD);
                prog.push_back(8'($urandom_range(255, usable)));
                broken = 1'b1;
            end else if (pick < 95) begin
                prog.push_back(OP_FUNC);
                prog.push_back(8'($urandom_range(255, 3)));
                broken = 1'b1;
            end else if (pick < 98) begin
                // Cut short: the next start lands in the middle of this item.
                prog.push_back($urandom_range(1) ? OP_POS : OP_SPD);
                if ($urandom_range(1))
                    prog.push_back(good_index(usable));
                repeat ($urandom_range(0, 3)) prog.push_back(8'($urandom_range(255)));
                broken = 1'b1;
            end else begin
                prog.push_back(OP_GROUP);
            end
        end
        if (!broken && $urandom_range(99) < 75)
            prog.push_back(OP_END);
        counted_bytes += prog.size();
        if ($urandom_range(99) < 20)
            prog.push_back(8'($urandom_range(255)));
        foreach (prog[i])
            send_word(prog[i], i == 0);
    endtask

    // Sets the limit while idle and then runs random routines with stray words.
    task automatic run_segment(input logic [3:0] lim, input int budget);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        limit_setting = lim;
        counted_bytes = 0;
        while (counted_bytes < budget) begin
            if ($urandom_range(99) < 6)
                repeat ($urandom_range(1, 3))
                    send_word(8'($urandom_range(255)), $urandom_range(99) < 30);
            else
                play_routine();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset limit of eight.
        send_word(8'h12, 1'b0);                              // dropped before any start
        send_word(OP_POS, 1'b1);                             // action before a group
        send_word(OP_LOCK, 1'b1);                            // lockdown before a group
        send_word(OP_GROUP, 1'b0);
        send_word(OP_POS, 1'b0); send_word(8'h07, 1'b0); send_word(8'hFF, 1'b0);
        send_word(OP_SPD, 1'b0); send_word(8'h00, 1'b0); send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0); send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b0); send_word(8'hFF, 1'b0);
        send_word(OP_FUNC, 1'b0); send_word(8'h02, 1'b0);
        send_word(OP_FUNC, 1'b0); send_word(8'h03, 1'b0);   // function out of range
        send_word(OP_GROUP, 1'b1); send_word(OP_SPD, 1'b0);
        send_word(8'h08, 1'b0);                              // actuator at the limit
        send_word(OP_GROUP, 1'b1); send_word(OP_POS, 1'b0);
        send_word(OP_GROUP, 1'b1);                           // restart mid-item
        send_word(8'h00, 1'b0);                              // unknown opcode
        send_word(OP_GROUP, 1'b1); send_word(OP_END, 1'b0);
        send_word(8'h44, 1'b0);                              // dropped after the end

        run_segment(4'd1, 210);
        run_segment(4'd5, 210);

        sender_idle_pct = 76;
        receiver_idle_pct = 14;
        run_segment(4'd8, 210);
        run_segment(4'd0, 210);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_segment(4'd15, 210);
        run_segment(4'd3, 200);

        // Long routine that drives the group count into saturation.
        send_word(OP_GROUP, 1'b1);
        repeat (259) send_word(OP_GROUP, 1'b0);
        send_word(OP_POS, 1'b0); send_word(8'h00, 1'b0); send_word(8'h5A, 1'b0);
        send_word(OP_END, 1'b0);

        settle_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
